// ----- src/uvs_pkg.sv -----
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int CfgWidth   = 16;
  localparam int CntWidth   = 9;
  localparam int DvdWidth   = 26;
  localparam int DvsWidth   = 10;
  localparam int PhaseWidth = 16;
  localparam int IdxWidth   = 17;

  typedef enum logic [1:0] {
    CFG_SEGMENTS = 2'd0,
    CFG_RINGS    = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                range_error;
    logic                has_quad;
    logic [IdxWidth-1:0] c_tl;
    logic [IdxWidth-1:0] c_tr;
    logic [IdxWidth-1:0] c_bl;
    logic [IdxWidth-1:0] c_br;
  } meta_t;

  typedef struct packed {
    logic [DvdWidth-1:0] dvd_t;
    logic [DvsWidth-1:0] dvs_t;
    logic [DvdWidth-1:0] dvd_p;
    logic [DvsWidth-1:0] dvs_p;
    meta_t               meta;
  } work_t;

endpackage

// ----- src/uvs_if.sv -----
`timescale 1ns / 1ps
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] ring;
  logic [7:0] segment;
  modport source(output valid, ring, segment, input ready);
  modport sink(input valid, ring, segment, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic        [16:0] corner_top_left;
  logic        [16:0] corner_top_right;
  logic        [16:0] corner_bottom_left;
  logic        [16:0] corner_bottom_right;
  logic               has_quad;
  logic               range_error;
  modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 corner_top_left, corner_top_right, corner_bottom_left,
                 corner_bottom_right, has_quad, range_error, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
               corner_top_left, corner_top_right, corner_bottom_left,
               corner_bottom_right, has_quad, range_error, output ready);
endinterface

// ----- src/uvs_front.sv -----
`timescale 1ns / 1ps
module uvs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [uvs_pkg::CntWidth-1:0]  ns,
  input  logic [uvs_pkg::CntWidth-1:0]  nr,
  uvs_in_if.sink                        in_ch,
  output logic                          push,
  output uvs_pkg::work_t                push_item,
  input  logic                          full
);
  import uvs_pkg::*;

  logic                  fv;
  work_t                 item;
  work_t                 item_next;
  logic                  err;
  logic                  quad;
  logic [18:0]           row_base;
  logic [18:0]           tl;
  logic [18:0]           tr;

  assign in_ch.ready = !fv || !full;
  assign push        = fv && !full;
  assign push_item   = item;

  always_comb begin
    err      = (in_ch.ring > nr) || ({1'b0, in_ch.segment} >= ns);
    quad     = !err && (in_ch.ring < nr);
    row_base = 19'(in_ch.ring * ns);
    tl       = row_base + 19'(in_ch.segment);
    tr       = (({1'b0, in_ch.segment} + 9'd1) < ns) ? tl + 19'd1 : row_base;
    item_next.dvd_t = {in_ch.segment, 17'd0} + DvdWidth'(ns);
    item_next.dvs_t = {ns, 1'b0};
    item_next.dvd_p = {1'b0, in_ch.ring, 16'd0} + DvdWidth'(nr);
    item_next.dvs_p = {nr, 1'b0};
    item_next.meta.range_error = err;
    item_next.meta.has_quad    = quad;
    item_next.meta.c_tl = quad ? tl[IdxWidth-1:0] : '0;
    item_next.meta.c_tr = quad ? tr[IdxWidth-1:0] : '0;
    item_next.meta.c_bl = quad ? IdxWidth'(tl + 19'(ns)) : '0;
    item_next.meta.c_br = quad ? IdxWidth'(tr + 19'(ns)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ch.ready) begin
      fv <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      item <= item_next;
    end
  end

  a_err_no_quad: assert property (@(posedge clk) disable iff (rst)
    fv && item.meta.range_error |-> !item.meta.has_quad)
    else $error("error item marked with quad");
  a_no_quad_zero: assert property (@(posedge clk) disable iff (rst)
    fv && !item.meta.has_quad |-> item.meta.c_tl == '0 && item.meta.c_br == '0)
    else $error("corners set without quad");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    fv && full |=> fv && $stable(item))
    else $error("front item lost while queue full");
endmodule

// ----- src/uvs_fifo.sv -----
`timescale 1ns / 1ps
module uvs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  uvs_pkg::work_t push_item,
  output logic           full,
  output logic           pop_valid,
  output uvs_pkg::work_t pop_item,
  input  logic           pop
);
  import uvs_pkg::*;

  work_t       mem [0:1];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_item  = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
  a_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");
endmodule

// ----- src/uvs_div.sv -----
`timescale 1ns / 1ps
module uvs_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [uvs_pkg::DvdWidth-1:0]   dividend,
  input  logic [uvs_pkg::DvsWidth-1:0]   divisor,
  output logic [uvs_pkg::PhaseWidth-1:0] quotient
);
  import uvs_pkg::*;

  logic [DvdWidth-1:0]   rr [0:PhaseWidth];
  logic [PhaseWidth-1:0] qq [0:PhaseWidth];
  logic [DvsWidth-1:0]   dd [0:PhaseWidth];

  assign rr[0]    = dividend;
  assign qq[0]    = '0;
  assign dd[0]    = divisor;
  assign quotient = qq[PhaseWidth];

  for (genvar k = 0; k < PhaseWidth; k++) begin : g_step
    logic [DvdWidth-1:0] sh;
    logic                ge;
    assign sh = DvdWidth'(dd[k]) << (PhaseWidth - 1 - k);
    assign ge = (rr[k] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rr[k+1] <= ge ? rr[k] - sh : rr[k];
        qq[k+1] <= qq[k] | (PhaseWidth'(ge) << (PhaseWidth - 1 - k));
        dd[k+1] <= dd[k];
      end
    end
  end
endmodule

// ----- src/uvs_sin.sv -----
`timescale 1ns / 1ps
module uvs_sin (
  input  logic                           clk,
  input  logic                           en,
  input  logic [uvs_pkg::PhaseWidth-1:0] phase,
  output logic signed [16:0]             val
);
  import uvs_pkg::*;

  localparam logic [12:0] PolyA = 13'd4640;
  localparam logic [15:0] PolyB = 16'd42048;
  localparam logic [16:0] PolyC = 17'd102944;

  logic [14:0] fm;
  logic [16:0] z0, z1, z2r, z3;
  logic [16:0] sq1, sq2;
  logic [15:0] t1;
  logic [16:0] t2;
  logic        n0, n1, n2, n3;
  logic [33:0] p1;
  logic [29:0] p2;
  logic [32:0] p3;
  logic [33:0] p4;
  logic [17:0] rnd;
  logic [16:0] mag;

  always_comb begin
    fm  = phase[14] ? 15'd16384 - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};
    p1  = z0 * z0;
    p2  = PolyA * sq1;
    p3  = t1 * sq2;
    p4  = t2 * z3;
    rnd = 18'((p4[33:16] + 18'd1) >> 1);
    mag = (rnd > 18'd32768) ? 17'd32768 : rnd[16:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0  <= {fm, 2'b00};
      n0  <= phase[15];
      z1  <= z0;
      sq1 <= p1[32:16];
      n1  <= n0;
      t1  <= PolyB - 16'(p2[29:16]);
      sq2 <= sq1;
      z2r <= z1;
      n2  <= n1;
      t2  <= PolyC - p3[32:16];
      z3  <= z2r;
      n3  <= n2;
      val <= n3 ? -$signed(mag) : $signed(mag);
    end
  end
endmodule

// ----- src/uvs_back.sv -----
`timescale 1ns / 1ps
module uvs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    radius,
  input  logic           item_valid,
  input  uvs_pkg::work_t item,
  output logic           take,
  uvs_out_if.source      out_ch
);
  import uvs_pkg::*;

  localparam int Depth = 23;
  localparam int ProdStage = 21;

  logic                  adv;
  logic [Depth-1:0]      v;
  meta_t                 meta [0:Depth-1];
  logic [PhaseWidth-1:0] qt, qp;
  logic signed [16:0]    st, ct, sp, cp;
  logic signed [16:0]    nx, ny, nz;
  logic signed [16:0]    nx_c, nz_c;
  logic signed [16:0]    px_c, py_c, pz_c;
  logic signed [16:0]    px, py, pz;
  logic signed [15:0]    sx, sy, sz;

  function automatic logic signed [16:0] mul_q15(logic signed [16:0] a,
                                                 logic signed [16:0] b);
    logic [15:0] ma, mb;
    logic [32:0] m;
    ma = 16'(a < 0 ? -a : a);
    mb = 16'(b < 0 ? -b : b);
    m  = ((33'(ma) * 33'(mb)) + 33'd16384) >> 15;
    return ((a < 0) != (b < 0)) ? -$signed(m[16:0]) : $signed(m[16:0]);
  endfunction

  function automatic logic signed [16:0] scale(logic signed [16:0] n,
                                               logic [15:0] r);
    logic [15:0] mn;
    logic [32:0] m;
    mn = 16'(n < 0 ? -n : n);
    m  = ((33'(mn) * 33'(r)) + 33'd16384) >> 15;
    return (n < 0) ? -$signed(m[16:0]) : $signed(m[16:0]);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [16:0] n);
    if (n > 17'sd32767) return 16'sh7fff;
    return n[15:0];
  endfunction

  assign adv  = !v[Depth-1] || out_ch.ready;
  assign take = adv;

  uvs_div u_div_t (.clk, .en(adv), .dividend(item.dvd_t), .divisor(item.dvs_t),
                   .quotient(qt));
  uvs_div u_div_p (.clk, .en(adv), .dividend(item.dvd_p), .divisor(item.dvs_p),
                   .quotient(qp));
  uvs_sin u_sin_t (.clk, .en(adv), .phase(qt), .val(st));
  uvs_sin u_cos_t (.clk, .en(adv), .phase(qt + 16'd16384), .val(ct));
  uvs_sin u_sin_p (.clk, .en(adv), .phase(qp), .val(sp));
  uvs_sin u_cos_p (.clk, .en(adv), .phase(qp + 16'd16384), .val(cp));

  always_comb begin
    nx_c = mul_q15(sp, ct);
    nz_c = mul_q15(sp, st);
    px_c = scale(nx, radius);
    py_c = scale(ny, radius);
    pz_c = scale(nz, radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[Depth-2:0], item_valid};
    end
    if (adv) begin
      meta[0] <= item.meta;
      for (int i = 1; i < Depth; i++) begin
        meta[i] <= meta[i-1];
      end
      nx <= nx_c;
      ny <= -cp;
      nz <= nz_c;
      px <= px_c;
      py <= py_c;
      pz <= pz_c;
      sx <= sat16(nx);
      sy <= sat16(ny);
      sz <= sat16(nz);
    end
  end

  assign out_ch.valid               = v[Depth-1];
  assign out_ch.pos_x               = meta[Depth-1].range_error ? '0 : px;
  assign out_ch.pos_y               = meta[Depth-1].range_error ? '0 : py;
  assign out_ch.pos_z               = meta[Depth-1].range_error ? '0 : pz;
  assign out_ch.norm_x              = meta[Depth-1].range_error ? '0 : sx;
  assign out_ch.norm_y              = meta[Depth-1].range_error ? '0 : sy;
  assign out_ch.norm_z              = meta[Depth-1].range_error ? '0 : sz;
  assign out_ch.corner_top_left     = meta[Depth-1].c_tl;
  assign out_ch.corner_top_right    = meta[Depth-1].c_tr;
  assign out_ch.corner_bottom_left  = meta[Depth-1].c_bl;
  assign out_ch.corner_bottom_right = meta[Depth-1].c_br;
  assign out_ch.has_quad            = meta[Depth-1].has_quad;
  assign out_ch.range_error         = meta[Depth-1].range_error;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v))
    else $error("pipeline moved while stalled");
  a_prod_stage: assert property (@(posedge clk) disable iff (rst)
    v[ProdStage] && meta[ProdStage].range_error |-> !meta[ProdStage].has_quad)
    else $error("error item with quad in pipeline");
  a_take: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !take)
    else $error("item taken while output stalled");
endmodule

// ----- src/uv_sphere_vertex_generator_top.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; a 16-stage
// pipelined divider per angle, a 5-stage sine lane per function and two
// multiply stages set the depth.
// Reset: synchronous, active high; clears all valid state and loads
// segments 32, rings 16, radius 1.0.
module uv_sphere_vertex_generator_top #(
  parameter int MAX_SEGMENTS = 256,
  parameter int MAX_RINGS    = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [uvs_pkg::CfgWidth-1:0]   cfg_data,
  uvs_in_if.sink                         in_ch,
  uvs_out_if.source                      out_ch
);
  import uvs_pkg::*;

  logic [CntWidth-1:0] segments;
  logic [CntWidth-1:0] rings;
  logic [15:0]         radius;
  logic [CntWidth-1:0] ns, nr;
  logic                push, full, pop_valid, take;
  work_t               push_item, pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= 9'd32;
      rings    <= 9'd16;
      radius   <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEGMENTS: segments <= cfg_data[CntWidth-1:0];
        CFG_RINGS:    rings    <= cfg_data[CntWidth-1:0];
        CFG_RADIUS:   radius   <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_comb begin
    ns = (segments == '0) ? 9'd1 :
         (32'(segments) > MAX_SEGMENTS) ? CntWidth'(MAX_SEGMENTS) : segments;
    nr = (rings == '0) ? 9'd1 :
         (32'(rings) > MAX_RINGS) ? CntWidth'(MAX_RINGS) : rings;
  end

  uvs_front u_front (.clk, .rst, .ns, .nr, .in_ch, .push, .push_item, .full);

  uvs_fifo u_fifo (.clk, .rst, .push, .push_item, .full, .pop_valid, .pop_item,
                   .pop(take));

  uvs_back u_back (.clk, .rst, .radius, .item_valid(pop_valid), .item(pop_item),
                   .take, .out_ch);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.range_error |-> out_ch.pos_x == '0 &&
    out_ch.norm_y == '0 && !out_ch.has_quad)
    else $error("error result carries data");
  a_noquad_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.has_quad |-> out_ch.corner_top_left == '0 &&
    out_ch.corner_bottom_right == '0)
    else $error("corners without quad");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid after reset");
endmodule

// ----- tb/sv/uv_sphere_vertex_generator_top_test.sv -----
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_top_test;
  import uvs_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;
  localparam int SphereMaxSegments = 256;
  localparam int SphereMaxRings = 256;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        c_tl;
    logic [16:0]        c_tr;
    logic [16:0]        c_bl;
    logic [16:0]        c_br;
    logic               has_quad;
    logic               range_error;
  } vertex_t;

  typedef struct {
    int      ring;
    int      seg;
    bit      typed;
    vertex_t vtx;
  } point_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CfgWidth-1:0] cfg_data;

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();

  uv_sphere_vertex_generator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  int unsigned seg_reg;
  int unsigned ring_reg;
  int unsigned rad_reg;
  vertex_t     vertex_q[$];
  int          fail_cnt;
  int          sent_cnt;
  int          hold_left;
  bit          held;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int sin_quarter(int unsigned f);
    longint unsigned z, z2, t, s, r;
    z  = longint'(f) << 2;
    z2 = (z * z) >> 16;
    t  = 42048 - ((4640 * z2) >> 16);
    t  = 102944 - ((t * z2) >> 16);
    s  = (t * z) >> 16;
    r  = (s + 1) >> 1;
    return (r > 32768) ? 32768 : int'(r);
  endfunction

  function automatic int sin_of_phase(int unsigned p);
    int unsigned q, f;
    int m;
    p = p & 32'hFFFF;
    q = p >> 14;
    f = p & 32'h3FFF;
    m = q[0] ? sin_quarter(16384 - f) : sin_quarter(f);
    return q[1] ? -m : m;
  endfunction

  function automatic int mul_q15(int a, int b);
    longint m;
    m = ((a < 0 ? -longint'(a) : longint'(a)) * (b < 0 ? -longint'(b) : longint'(b))
         + 16384) >>> 15;
    return ((a < 0) != (b < 0)) ? -int'(m) : int'(m);
  endfunction

  function automatic int scale_by_radius(int n);
    longint m;
    m = ((n < 0 ? -longint'(n) : longint'(n)) * longint'(rad_reg) + 16384) >>> 15;
    return (n < 0) ? -int'(m) : int'(m);
  endfunction

  function automatic int sat16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int eff_segments();
    return (seg_reg == 0) ? 1 : ((seg_reg > SphereMaxSegments) ? SphereMaxSegments : seg_reg);
  endfunction

  function automatic int eff_rings();
    return (ring_reg == 0) ? 1 : ((ring_reg > SphereMaxRings) ? SphereMaxRings : ring_reg);
  endfunction

  function automatic vertex_t sphere_vertex(int ring, int seg);
    vertex_t v;
    longint ns, nr, tl, tr;
    int tp, pp, st, ct, sp, cp, nx, ny, nz;
    v  = '0;
    ns = eff_segments();
    nr = eff_rings();
    if (ring > nr || seg >= ns) begin
      v.range_error = 1'b1;
      return v;
    end
    tp = int'((longint'(seg) * 131072 + ns) / (2 * ns));
    pp = int'((longint'(ring) * 65536 + nr) / (2 * nr));
    st = sin_of_phase(tp);
    ct = sin_of_phase(tp + 16384);
    sp = sin_of_phase(pp);
    cp = sin_of_phase(pp + 16384);
    nx = mul_q15(sp, ct);
    ny = -cp;
    nz = mul_q15(sp, st);
    v.pos_x  = 17'(scale_by_radius(nx));
    v.pos_y  = 17'(scale_by_radius(ny));
    v.pos_z  = 17'(scale_by_radius(nz));
    v.norm_x = 16'(sat16(nx));
    v.norm_y = 16'(sat16(ny));
    v.norm_z = 16'(sat16(nz));
    if (ring < nr) begin
      tl = ring * ns + seg;
      tr = (seg + 1 < ns) ? tl + 1 : ring * ns;
      v.c_tl     = 17'(tl);
      v.c_tr     = 17'(tr);
      v.c_bl     = 17'(tl + ns);
      v.c_br     = 17'(tr + ns);
      v.has_quad = 1'b1;
    end
    return v;
  endfunction

  function automatic vertex_t error_vertex();
    vertex_t v;
    v = '0;
    v.range_error = 1'b1;
    return v;
  endfunction

  function automatic vertex_t pole_vertex(int ny, int py, bit quad);
    vertex_t v;
    v = '0;
    v.norm_y   = 16'(ny);
    v.pos_y    = 17'(py);
    v.has_quad = quad;
    if (quad) begin
      v.c_tr = 17'd1;
      v.c_bl = 17'd32;
      v.c_br = 17'd33;
    end
    return v;
  endfunction

  // receiver: random stalls, one long hold-off, one quiet stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      held         <= 1'b0;
    end else if (!held && sent_cnt == 150) begin
      held         <= 1'b1;
      hold_left    <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sent_cnt >= 300 && sent_cnt < 420) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.norm_x, out_ch.norm_y,
              out_ch.norm_z, out_ch.corner_top_left, out_ch.corner_top_right,
              out_ch.corner_bottom_left, out_ch.corner_bottom_right, out_ch.has_quad,
              out_ch.range_error};
      if (vertex_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected vertex %p", got);
      end else begin
        want = vertex_q.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.pos_z !== want.pos_z || got.norm_x !== want.norm_x ||
            got.norm_y !== want.norm_y || got.norm_z !== want.norm_z ||
            got.c_tl !== want.c_tl || got.c_tr !== want.c_tr ||
            got.c_bl !== want.c_bl || got.c_br !== want.c_br ||
            got.has_quad !== want.has_quad || got.range_error !== want.range_error) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("vertex mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic send_point(int ring, int seg, bit typed, vertex_t vtx);
    if (!(sent_cnt >= 300 && sent_cnt < 420) && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.ring    <= 9'(ring);
    in_ch.segment <= 8'(seg);
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    vertex_q.push_back(typed ? vtx : sphere_vertex(ring, seg));
    sent_cnt++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgWidth'(val);
    @(posedge clk);
    case (idx)
      CFG_SEGMENTS: seg_reg  = val & 32'h1FF;
      CFG_RINGS:    ring_reg = val & 32'h1FF;
      CFG_RADIUS:   rad_reg  = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic random_points(int n);
    int ns, nr, r, s;
    ns = eff_segments();
    nr = eff_rings();
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin
          r = $urandom_range(0, 511);
          s = $urandom_range(0, 255);
        end
        1: begin
          r = nr;
          s = $urandom_range(0, ns - 1);
        end
        default: begin
          r = $urandom_range(0, nr);
          s = $urandom_range(0, ns - 1);
        end
      endcase
      send_point(r, s, 1'b0, '0);
    end
  endtask

  point_row_t rows[$];
  int         phase;

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SEGMENTS;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.ring    = '0;
    in_ch.segment = '0;
    fail_cnt      = 0;
    sent_cnt      = 0;
    seg_reg       = 32;
    ring_reg      = 16;
    rad_reg       = 256;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{0, 0, 1'b1, pole_vertex(-32768, -256, 1'b1)},
      '{16, 0, 1'b1, pole_vertex(32767, 256, 1'b0)},
      '{17, 0, 1'b1, error_vertex()},
      '{0, 32, 1'b1, error_vertex()},
      '{511, 255, 1'b1, error_vertex()},
      '{256, 0, 1'b1, error_vertex()},
      '{8, 8, 1'b0, '0},
      '{8, 31, 1'b0, '0},
      '{15, 31, 1'b0, '0},
      '{16, 31, 1'b0, '0},
      '{4, 16, 1'b0, '0},
      '{12, 24, 1'b0, '0},
      '{1, 1, 1'b0, '0},
      '{0, 31, 1'b0, '0},
      '{7, 13, 1'b0, '0}
    };
    foreach (rows[i]) send_point(rows[i].ring, rows[i].seg, rows[i].typed, rows[i].vtx);
    random_points(40);
    drain();

    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_SEGMENTS, 1);
          write_reg(CFG_RINGS, 1);
          write_reg(CFG_RADIUS, 65535);
        end
        1: begin
          write_reg(CFG_SEGMENTS, 256);
          write_reg(CFG_RINGS, 256);
          write_reg(CFG_RADIUS, 0);
        end
        2: begin
          write_reg(CFG_SEGMENTS, 0);
          write_reg(CFG_RINGS, 0);
          write_reg(CFG_RADIUS, 65535);
        end
        3: begin
          write_reg(CFG_SEGMENTS, 511);
          write_reg(CFG_RINGS, 300);
          write_reg(CFG_RADIUS, $urandom_range(0, 65535));
          write_reg(CfgSpare, 16'hFFFF);
        end
        4: begin
          write_reg(CFG_SEGMENTS, 3);
          write_reg(CFG_RINGS, 2);
          write_reg(CFG_RADIUS, 256);
        end
        default: begin
          write_reg(CFG_SEGMENTS, $urandom_range(1, 256));
          write_reg(CFG_RINGS, $urandom_range(1, 256));
          write_reg(CFG_RADIUS, $urandom_range(0, 65535));
        end
      endcase
      cfg_we <= 1'b0;
      random_points(phase == 1 ? 120 : 60);
      drain();
    end

    if (fail_cnt == 0 && vertex_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/uvs_pkg.sv
src/uvs_if.sv
src/uvs_front.sv
src/uvs_fifo.sv
src/uvs_div.sv
src/uvs_sin.sv
src/uvs_back.sv
src/uv_sphere_vertex_generator_top.sv
tb/sv/uv_sphere_vertex_generator_top_test.sv
